/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/jrc_pkg.sv */
`default_nettype none
package jrc_pkg;
   localparam int IN_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF = 30;
   // normalized magnitude width of |d| and 2|b|
   localparam int NORM_W = 62;
   // square roots: 63 root bits, remainder one bit over twice that
   localparam int ROOT_W = 63;
   localparam int RAD_W  = 2 * ROOT_W + 1;
   // dividers: 64-bit divisor, 64 quotient bits
   localparam int DIV_W  = 64;
   localparam int QUO_W  = 64;
   // multiplier split
   localparam int HALF_W = 31;
   localparam int MUL_W  = 32;
endpackage
`default_nettype wire

/* sv/jrc_norm_cell.sv */
`default_nettype none
module jrc_norm_cell #(
   parameter int LW  = 95,
   parameter int AMT = 1,
   parameter int SW  = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          up_vld,
   input  wire logic [LW-1:0] up_pw,
   input  wire logic [LW-1:0] up_qw,
   input  wire logic [SW-1:0] up_side,
   output logic               dn_vld,
   output logic [LW-1:0]      dn_pw,
   output logic [LW-1:0]      dn_qw,
   output logic [SW-1:0]      dn_side
);
   logic          vld_ff;
   logic [LW-1:0] pw_ff, pw_in, qw_ff, qw_in;
   logic [SW-1:0] side_ff;
   logic [AMT-1:0] top_bits;

   // shift both words left when the top AMT bits of both are clear
   always_comb begin
      top_bits = up_pw[LW-1 -: AMT] | up_qw[LW-1 -: AMT];
      if (top_bits == '0) begin
         pw_in = up_pw << AMT;
         qw_in = up_qw << AMT;
      end else begin
         pw_in = up_pw;
         qw_in = up_qw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pw_ff   <= pw_in;
         qw_ff   <= qw_in;
         side_ff <= up_side;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_pw   = pw_ff;
   assign dn_qw   = qw_ff;
   assign dn_side = side_ff;
endmodule
`default_nettype wire

/* sv/jrc_sqrt_cell.sv */
`default_nettype none
module jrc_sqrt_cell #(
   parameter int BIT = 0,
   parameter int SW  = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        up_vld,
   input  wire logic [jrc_pkg::RAD_W-1:0]   up_rem,
   input  wire logic [jrc_pkg::ROOT_W-1:0]  up_root,
   input  wire logic [SW-1:0]               up_side,
   output logic                             dn_vld,
   output logic [jrc_pkg::RAD_W-1:0]        dn_rem,
   output logic [jrc_pkg::ROOT_W-1:0]       dn_root,
   output logic [SW-1:0]                    dn_side
);
   import jrc_pkg::*;

   logic              vld_ff;
   logic [RAD_W-1:0]  rem_ff, rem_in, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SW-1:0]     side_ff;
   logic              ge;

   // rem = n - root^2; trying root bit BIT costs root*2^(BIT+1) + 2^(2*BIT)
   always_comb begin
      trial = ({{(RAD_W-ROOT_W){1'b0}}, up_root} << (BIT + 1))
            | ({{(RAD_W-1){1'b0}}, 1'b1} << (2 * BIT));
      ge    = up_rem >= trial;
      if (ge) begin
         rem_in  = up_rem - trial;
         root_in = up_root | ({{(ROOT_W-1){1'b0}}, 1'b1} << BIT);
      end else begin
         rem_in  = up_rem;
         root_in = up_root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_side = side_ff;
endmodule
`default_nettype wire

/* sv/jrc_div_cell.sv */
`default_nettype none
// One restoring-division step for two independent lanes.
module jrc_div_cell #(
   parameter int SW = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              adv,
   input  wire logic                              up_vld,
   input  wire logic [1:0][jrc_pkg::DIV_W-1:0]    up_rem,
   input  wire logic [1:0][jrc_pkg::DIV_W-1:0]    up_dv,
   input  wire logic [1:0][jrc_pkg::QUO_W-1:0]    up_num,
   input  wire logic [1:0][jrc_pkg::QUO_W-1:0]    up_quo,
   input  wire logic [SW-1:0]                     up_side,
   output logic                                   dn_vld,
   output logic [1:0][jrc_pkg::DIV_W-1:0]         dn_rem,
   output logic [1:0][jrc_pkg::DIV_W-1:0]         dn_dv,
   output logic [1:0][jrc_pkg::QUO_W-1:0]         dn_num,
   output logic [1:0][jrc_pkg::QUO_W-1:0]         dn_quo,
   output logic [SW-1:0]                          dn_side
);
   import jrc_pkg::*;

   logic                   vld_ff;
   logic [1:0][DIV_W-1:0]  rem_ff, rem_in, dv_ff;
   logic [1:0][QUO_W-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [SW-1:0]          side_ff;
   logic [DIV_W:0]         shifted [2];
   logic [DIV_W:0]         diff [2];
   logic [1:0]             ge;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         shifted[l] = {up_rem[l], up_num[l][QUO_W-1]};
         diff[l]    = shifted[l] - {1'b0, up_dv[l]};
         ge[l]      = shifted[l] >= {1'b0, up_dv[l]};
         rem_in[l]  = ge[l] ? diff[l][DIV_W-1:0] : shifted[l][DIV_W-1:0];
         quo_in[l]  = {up_quo[l][QUO_W-2:0], ge[l]};
         num_in[l]  = up_num[l] << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         dv_ff   <= up_dv;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         side_ff <= up_side;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_rem  = rem_ff;
   assign dn_dv   = dv_ff;
   assign dn_num  = num_ff;
   assign dn_quo  = quo_ff;
   assign dn_side = side_ff;
endmodule
`default_nettype wire

/* sv/jacobi_rotation_coefficients.sv */
//  channel | dir | tdata fields (low bit up)                     | tuser/tlast
//  req_    | in  | diag_first, off_diag, diag_second (IN_WIDTH)   | none
//  rsp_    | out | cos_value (FRAC_BITS+1), sin_value (FRAC_BITS+1) | none
//
//  One item accepted per clock while the chain is not stalled; every item
//  runs through the same chain of cells, mostly the two bitwise square-root
//  rows and the 64-cell divider row, one result bit per cell.
//  Reset (synchronous) clears only the valid bits of the chain and output.
//  A stalled result holds the output register; the chain keeps moving until
//  its last cell holds an item too, then the whole chain stops together.
`default_nettype none
`include "assert_macros.svh"
module jacobi_rotation_coefficients #(
   parameter int IN_WIDTH  = jrc_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = jrc_pkg::FRAC_BITS_DEF,
   localparam int REQ_W = ((3 * IN_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((2 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // diag_first, off_diag, diag_second
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // cos_value, sin_value
   output logic [RSP_W-1:0]      rsp_tdata
);
   import jrc_pkg::*;

   localparam int W     = IN_WIDTH + 1;
   localparam int LW    = W + NORM_W;
   localparam int NS    = $clog2(W);
   localparam int OUT_W = FRAC_BITS + 1;
   localparam int SHC   = NORM_W - FRAC_BITS;
   localparam int PW    = 2 * MUL_W * 2;

   logic adv;

   // ---------------- input stage: |d|, 2|b|, sign of the rotation, zero off-diagonal flag
   logic [IN_WIDTH-1:0] x_raw, b_raw, y_raw;
   logic [W-1:0]        xs, ys, bs, diff, p_cur, bmag, q_cur;
   logic                dpos, dneg, bneg, neg_cur, zero_cur;

   assign x_raw = req_tdata[IN_WIDTH-1:0];
   assign b_raw = req_tdata[2*IN_WIDTH-1:IN_WIDTH];
   assign y_raw = req_tdata[3*IN_WIDTH-1:2*IN_WIDTH];

   always_comb begin
      xs       = {x_raw[IN_WIDTH-1], x_raw};
      ys       = {y_raw[IN_WIDTH-1], y_raw};
      bs       = {b_raw[IN_WIDTH-1], b_raw};
      diff     = ys - xs;
      dneg     = diff[W-1];
      dpos     = !diff[W-1] && (diff != '0);
      p_cur    = dneg ? (~diff + 1'b1) : diff;
      bneg     = b_raw[IN_WIDTH-1];
      bmag     = bneg ? (~bs + 1'b1) : bs;
      q_cur    = bmag << 1;
      zero_cur = (b_raw == '0);
      neg_cur  = (bneg && dpos) || (!bneg && dneg);
   end

   logic         a_vld_ff;
   logic [W-1:0] a_p_ff, a_q_ff;
   logic         a_neg_ff, a_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_p_ff    <= p_cur;
         a_q_ff    <= q_cur;
         a_neg_ff  <= neg_cur;
         a_zero_ff <= zero_cur;
      end
   end

   // ---------------- normalize: larger of |d|, 2|b| to exactly 62 bits
   logic [NS:0]   nrm_vld;
   logic [LW-1:0] nrm_pw [NS+1];
   logic [LW-1:0] nrm_qw [NS+1];
   logic [1:0]    nrm_side [NS+1];

   assign nrm_vld[0]  = a_vld_ff;
   assign nrm_pw[0]   = {a_p_ff, {NORM_W{1'b0}}};
   assign nrm_qw[0]   = {a_q_ff, {NORM_W{1'b0}}};
   assign nrm_side[0] = {a_neg_ff, a_zero_ff};

   for (genvar k = 0; k < NS; k++) begin : g_norm
      jrc_norm_cell #(.LW(LW), .AMT(1 << (NS - 1 - k)), .SW(2)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_vld  (nrm_vld[k]),
         .up_pw   (nrm_pw[k]),
         .up_qw   (nrm_qw[k]),
         .up_side (nrm_side[k]),
         .dn_vld  (nrm_vld[k+1]),
         .dn_pw   (nrm_pw[k+1]),
         .dn_qw   (nrm_qw[k+1]),
         .dn_side (nrm_side[k+1])
      );
   end

   logic [NORM_W-1:0] np, nq;
   assign np = nrm_pw[NS][LW-1 -: NORM_W];
   assign nq = nrm_qw[NS][LW-1 -: NORM_W];

   // ---------------- P^2 + Q^2 over three stages
   logic                  m1_vld_ff, m2_vld_ff, m3_vld_ff;
   logic [2*HALF_W-1:0]   m1_pll_ff, m1_plh_ff, m1_phh_ff;
   logic [2*HALF_W-1:0]   m1_qll_ff, m1_qlh_ff, m1_qhh_ff;
   logic [NORM_W-1:0]     m1_p_ff, m1_q_ff, m2_p_ff, m2_q_ff, m3_p_ff, m3_q_ff;
   logic [1:0]            m1_side_ff, m2_side_ff, m3_side_ff;
   logic [2*NORM_W-1:0]   m2_psq_ff, m2_qsq_ff, psq_in, qsq_in;
   logic [2*NORM_W:0]     m3_sum_ff;

   always_comb begin
      psq_in = ((2*NORM_W)'(m1_phh_ff) << (2 * HALF_W))
             + ((2*NORM_W)'(m1_plh_ff) << (HALF_W + 1))
             + (2*NORM_W)'(m1_pll_ff);
      qsq_in = ((2*NORM_W)'(m1_qhh_ff) << (2 * HALF_W))
             + ((2*NORM_W)'(m1_qlh_ff) << (HALF_W + 1))
             + (2*NORM_W)'(m1_qll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= nrm_vld[NS];
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_pll_ff  <= np[HALF_W-1:0] * np[HALF_W-1:0];
         m1_plh_ff  <= np[HALF_W-1:0] * np[NORM_W-1:HALF_W];
         m1_phh_ff  <= np[NORM_W-1:HALF_W] * np[NORM_W-1:HALF_W];
         m1_qll_ff  <= nq[HALF_W-1:0] * nq[HALF_W-1:0];
         m1_qlh_ff  <= nq[HALF_W-1:0] * nq[NORM_W-1:HALF_W];
         m1_qhh_ff  <= nq[NORM_W-1:HALF_W] * nq[NORM_W-1:HALF_W];
         m1_p_ff    <= np;
         m1_q_ff    <= nq;
         m1_side_ff <= nrm_side[NS];
         m2_psq_ff  <= psq_in;
         m2_qsq_ff  <= qsq_in;
         m2_p_ff    <= m1_p_ff;
         m2_q_ff    <= m1_q_ff;
         m2_side_ff <= m1_side_ff;
         m3_sum_ff  <= {1'b0, m2_psq_ff} + {1'b0, m2_qsq_ff};
         m3_p_ff    <= m2_p_ff;
         m3_q_ff    <= m2_q_ff;
         m3_side_ff <= m2_side_ff;
      end
   end

   // ---------------- r = isqrt(P^2 + Q^2), one root bit per cell
   localparam int S1W = 2 * NORM_W + 2;

   logic [ROOT_W:0]   s1_vld;
   logic [RAD_W-1:0]  s1_rem [ROOT_W+1];
   logic [ROOT_W-1:0] s1_root [ROOT_W+1];
   logic [S1W-1:0]    s1_side [ROOT_W+1];

   assign s1_vld[0]  = m3_vld_ff;
   assign s1_rem[0]  = RAD_W'(m3_sum_ff);
   assign s1_root[0] = '0;
   assign s1_side[0] = {m3_p_ff, m3_q_ff, m3_side_ff};

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt1
      jrc_sqrt_cell #(.BIT(ROOT_W - 1 - k), .SW(S1W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_vld  (s1_vld[k]),
         .up_rem  (s1_rem[k]),
         .up_root (s1_root[k]),
         .up_side (s1_side[k]),
         .dn_vld  (s1_vld[k+1]),
         .dn_rem  (s1_rem[k+1]),
         .dn_root (s1_root[k+1]),
         .dn_side (s1_side[k+1])
      );
   end

   // ---------------- r + P
   logic              rs_vld_ff;
   logic [ROOT_W-1:0] rs_r_ff;
   logic [DIV_W-1:0]  rs_rp_ff;
   logic [NORM_W-1:0] rs_q_ff;
   logic [1:0]        rs_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_vld_ff <= 1'b0;
      end else if (adv) begin
         rs_vld_ff <= s1_vld[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rs_r_ff    <= s1_root[ROOT_W];
         rs_rp_ff   <= DIV_W'(s1_root[ROOT_W])
                     + DIV_W'(s1_side[ROOT_W][S1W-1 -: NORM_W]);
         rs_q_ff    <= s1_side[ROOT_W][NORM_W+1:2];
         rs_side_ff <= s1_side[ROOT_W][1:0];
      end
   end

   // ---------------- lane 0: X = (r+P)*2^62 / r ; lane 1: T = Q*2^63 / (r+P)
   logic [QUO_W:0]            dv_vld;
   logic [1:0][DIV_W-1:0]     dv_rem [QUO_W+1];
   logic [1:0][DIV_W-1:0]     dv_dv  [QUO_W+1];
   logic [1:0][QUO_W-1:0]     dv_num [QUO_W+1];
   logic [1:0][QUO_W-1:0]     dv_quo [QUO_W+1];
   logic [1:0]                dv_side [QUO_W+1];

   assign dv_vld[0]     = rs_vld_ff;
   assign dv_rem[0][0]  = DIV_W'(rs_rp_ff >> 2);
   assign dv_num[0][0]  = {rs_rp_ff[1:0], {(QUO_W-2){1'b0}}};
   assign dv_dv[0][0]   = DIV_W'(rs_r_ff);
   assign dv_rem[0][1]  = DIV_W'(rs_q_ff >> 1);
   assign dv_num[0][1]  = {rs_q_ff[0], {(QUO_W-1){1'b0}}};
   assign dv_dv[0][1]   = rs_rp_ff;
   assign dv_quo[0]     = '0;
   assign dv_side[0]    = rs_side_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      jrc_div_cell #(.SW(2)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_vld  (dv_vld[k]),
         .up_rem  (dv_rem[k]),
         .up_dv   (dv_dv[k]),
         .up_num  (dv_num[k]),
         .up_quo  (dv_quo[k]),
         .up_side (dv_side[k]),
         .dn_vld  (dv_vld[k+1]),
         .dn_rem  (dv_rem[k+1]),
         .dn_dv   (dv_dv[k+1]),
         .dn_num  (dv_num[k+1]),
         .dn_quo  (dv_quo[k+1]),
         .dn_side (dv_side[k+1])
      );
   end

   // ---------------- C = isqrt(X * 2^61)
   localparam int S2W = QUO_W + 2;

   logic [ROOT_W:0]   s2_vld;
   logic [RAD_W-1:0]  s2_rem [ROOT_W+1];
   logic [ROOT_W-1:0] s2_root [ROOT_W+1];
   logic [S2W-1:0]    s2_side [ROOT_W+1];

   assign s2_vld[0]  = dv_vld[QUO_W];
   assign s2_rem[0]  = RAD_W'({dv_quo[QUO_W][0], {(NORM_W-1){1'b0}}});
   assign s2_root[0] = '0;
   assign s2_side[0] = {dv_quo[QUO_W][1], dv_side[QUO_W]};

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt2
      jrc_sqrt_cell #(.BIT(ROOT_W - 1 - k), .SW(S2W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_vld  (s2_vld[k]),
         .up_rem  (s2_rem[k]),
         .up_root (s2_root[k]),
         .up_side (s2_side[k]),
         .dn_vld  (s2_vld[k+1]),
         .dn_rem  (s2_rem[k+1]),
         .dn_root (s2_root[k+1]),
         .dn_side (s2_side[k+1])
      );
   end

   // ---------------- T*C in four partial products, then sum and round
   logic [QUO_W-1:0]  tq;
   logic [ROOT_W-1:0] cf;
   assign tq = s2_side[ROOT_W][S2W-1:2];
   assign cf = s2_root[ROOT_W];

   logic                          p1_vld_ff, p2_vld_ff;
   logic [MUL_W+ROOT_W-MUL_W-1:0] p1_unused_guard;
   logic [2*MUL_W-2:0]            p1_hh_ff, p1_lh_ff;
   logic [2*MUL_W-1:0]            p1_hl_ff, p1_ll_ff;
   logic [ROOT_W-1:0]             p1_c_ff;
   logic [1:0]                    p1_side_ff, p2_side_ff;
   logic [PW-1:0]                 p2_prod_ff, prod_in;
   logic [OUT_W-1:0]              p2_cos_ff;
   logic [ROOT_W+1:0]             cos_sum;

   assign p1_unused_guard = cf;

   always_comb begin
      prod_in = (PW'(p1_hh_ff) << (2 * MUL_W))
              + (PW'(p1_hl_ff) << MUL_W)
              + (PW'(p1_lh_ff) << MUL_W)
              + PW'(p1_ll_ff)
              + (PW'(1) << (2 * NORM_W - FRAC_BITS));
      cos_sum = {1'b0, p1_c_ff, 1'b0} + ((ROOT_W+2)'(1) << SHC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= s2_vld[ROOT_W];
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_hh_ff   <= tq[QUO_W-1:MUL_W] * p1_unused_guard[ROOT_W-1:MUL_W];
         p1_hl_ff   <= tq[QUO_W-1:MUL_W] * p1_unused_guard[MUL_W-1:0];
         p1_lh_ff   <= tq[MUL_W-1:0] * p1_unused_guard[ROOT_W-1:MUL_W];
         p1_ll_ff   <= tq[MUL_W-1:0] * p1_unused_guard[MUL_W-1:0];
         p1_c_ff    <= cf;
         p1_side_ff <= s2_side[ROOT_W][1:0];
         p2_prod_ff <= prod_in;
         p2_cos_ff  <= OUT_W'(cos_sum >> (SHC + 1));
         p2_side_ff <= p1_side_ff;
      end
   end

   // ---------------- output register
   logic             out_vld_ff;
   logic [OUT_W-1:0] out_cos_ff, out_sin_ff, smag, sin_in, cos_in;
   logic             out_load;

   always_comb begin
      smag = OUT_W'(p2_prod_ff >> (2 * NORM_W + 1 - FRAC_BITS));
      if (p2_side_ff[0]) begin
         cos_in = OUT_W'(1) << FRAC_BITS;
         sin_in = '0;
      end else begin
         cos_in = p2_cos_ff;
         sin_in = p2_side_ff[1] ? (~smag + 1'b1) : smag;
      end
   end

   // the chain stops only when its last cell holds an item the output cannot take
   assign adv      = !p2_vld_ff || !out_vld_ff || rsp_tready;
   assign out_load = p2_vld_ff && (!out_vld_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cos_ff <= cos_in;
         out_sin_ff <= sin_in;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_W'({out_sin_ff, out_cos_ff});

   `ASSERT_IMPL(a_ready_when_out_empty, clock, reset, !out_vld_ff, req_tready, "input blocked with empty output")
   `ASSERT_NEXT(a_accept_enters_chain, clock, reset, req_tvalid && req_tready, a_vld_ff, "accepted item lost")
   `ASSERT_IMPL(a_cos_at_most_one, clock, reset, out_vld_ff, out_cos_ff <= (OUT_W'(1) << FRAC_BITS), "cosine above one")
endmodule
`default_nettype wire

/* sim/jrc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module jrc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   output int               errors,
   output int               pending
);
   typedef struct packed {
      logic [30:0] cos_q;
      logic [30:0] sin_q;
   } rot_t;

   rot_t rot_fifo[$];

   function automatic int unsigned msb_count(logic [63:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
      return n;
   endfunction

   function automatic logic [63:0] sqrt_floor(logic [127:0] v);
      logic [63:0]  root;
      logic [63:0]  cand;
      logic [127:0] sq;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         sq = {64'd0, cand} * {64'd0, cand};
         if (sq <= v) root = cand;
      end
      return root;
   endfunction

   // cos/sin of the rotation that zeroes the off-diagonal entry
   function automatic rot_t rotation(logic [31:0] x, logic [31:0] b, logic [31:0] y);
      rot_t         res;
      logic signed [33:0] dv, bs;
      logic [63:0]  p, bm, pn, qn, r, rp, xq, cf, tq, smag, cosv;
      logic [127:0] prod;
      int unsigned  m, k;
      logic         neg;
      dv = $signed({{2{y[31]}}, y}) - $signed({{2{x[31]}}, x});
      bs = $signed({{2{b[31]}}, b});
      if (bs == 0) begin
         res.cos_q = 31'd1 << 30;
         res.sin_q = '0;
         return res;
      end
      p  = dv < 0 ? 64'(-dv) : 64'(dv);
      bm = bs < 0 ? 64'(-bs) : 64'(bs);
      neg = (bs < 0 && dv > 0) || (bs > 0 && dv < 0);
      m = msb_count(p);
      if (msb_count(bm) + 1 > m) m = msb_count(bm) + 1;
      if (m > 62) begin
         k  = m - 62;
         pn = p >> k;
         qn = bm >> (k - 1);
      end else begin
         pn = p << (62 - m);
         qn = bm << (63 - m);
      end
      r    = sqrt_floor({64'd0, pn} * {64'd0, pn} + {64'd0, qn} * {64'd0, qn});
      rp   = r + pn;
      xq   = 64'(({64'd0, rp} << 62) / {64'd0, r});
      cf   = sqrt_floor({64'd0, xq} << 61);
      tq   = 64'(({64'd0, qn} << 63) / {64'd0, rp});
      prod = {64'd0, tq} * {64'd0, cf} + (128'd1 << 94);
      smag = 64'(prod >> 95);
      cosv = (cf + (64'd1 << 31)) >> 32;
      res.cos_q = cosv[30:0];
      res.sin_q = neg ? 31'(-smag) : smag[30:0];
      return res;
   endfunction

   assign pending = rot_fifo.size();

   always @(posedge clock) begin
      rot_t want, got;
      if (reset) begin
         errors <= 0;
      end else begin
         if (req_tvalid && req_tready)
            rot_fifo.push_back(rotation(req_tdata[31:0], req_tdata[63:32], req_tdata[95:64]));
         if (rsp_tvalid && rsp_tready) begin
            got.cos_q = rsp_tdata[30:0];
            got.sin_q = rsp_tdata[61:31];
            if (rot_fifo.size() == 0) begin
               $display("%0t: result %h with none expected", $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = rot_fifo.pop_front();
               if (got.cos_q !== want.cos_q || got.sin_q !== want.sin_q) begin
                  $display("%0t: cos exp %h got %h, sin exp %h got %h", $time,
                           want.cos_q, got.cos_q, want.sin_q, got.sin_q);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* sim/tb_jacobi_rotation_coefficients.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_jacobi_rotation_coefficients;
   localparam int STALL_LIMIT = 5000;  // pipe is ~204 deep, stalls are short
   localparam int DRAIN_WAIT  = 260;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // diag_first, off_diag, diag_second
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // cos_value, sin_value, zero fill
   int          errors, pending;
   int          send_idle = 0;    // percent of cycles the sender holds off
   int          recv_idle = 0;    // percent of cycles the receiver stalls
   int          quiet = 0;

   jacobi_rotation_coefficients u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   jrc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   // watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one item; called at a falling edge, returns at a falling edge
   task automatic send_item(logic [31:0] x, logic [31:0] b, logic [31:0] y);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {y, b, x};
      #1;
      while (!req_tready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(200)) - 100);
         2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                     : 32'h80000000 + $urandom_range(3);
         3: return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_items(int n);
      logic [31:0] x, b, y;
      for (int i = 0; i < n; i++) begin
         x = pick_value();
         b = pick_value();
         y = pick_value();
         case ($urandom_range(9))
            0: b = '0;          // no rotation needed
            1: y = x;           // equal diagonals
            2: b = 32'($signed($urandom_range(6)) - 3);  // tiny b, gap dominates
            default: ;
         endcase
         send_item(x, b, y);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: zero off-diagonal, equal diagonals, sign cases, extremes
      send_item(32'd5, 32'd0, 32'd9);
      send_item(32'h80000000, 32'd0, 32'h7fffffff);
      send_item(32'd7, 32'd3, 32'd7);
      send_item(32'd7, -32'd3, 32'd7);
      send_item(32'd0, 32'h80000000, 32'd0);
      send_item(32'd0, 32'h7fffffff, 32'd0);
      send_item(32'd1, 32'd1, 32'd2);
      send_item(32'd2, 32'd1, 32'd1);
      send_item(32'd1, -32'd1, 32'd2);
      send_item(32'd2, -32'd1, 32'd1);
      send_item(32'h80000000, 32'd1, 32'h7fffffff);   // huge gap, tiny b
      send_item(32'h7fffffff, -32'd1, 32'h80000000);
      send_item(32'h80000000, 32'h80000000, 32'h7fffffff);
      send_item(32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_item(32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_item(32'h80000000, 32'h80000000, 32'h80000000);
      send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_item(32'h55555555, 32'haaaaaaaa, 32'h33333333);
      send_item(32'haaaaaaaa, 32'h55555555, 32'hcccccccc);
      req_tvalid <= 0;

      // hold off until the pipe has fully drained
      while (pending != 0) @(negedge clock);

      send_idle = 22;
      recv_idle = 56;
      random_items(430);
      send_idle = 56;
      recv_idle = 22;
      random_items(430);
      send_idle = 0;
      recv_idle = 0;
      random_items(430);
      req_tvalid <= 0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire
